/* src/gpb_pkg.sv */
// Shared types, constants and helper functions for the ground-plane back-projection block.
// Used by gpb_div and ground_plane_backprojection; depends on nothing else.
package gpb_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_REGS      = 8;
	localparam int REG_IDX_W     = 3;
	localparam int CFG_W         = 64;
	localparam int BOX_W         = 16;
	localparam int OUT_W         = 32;
	localparam int QUO_W         = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FOCAL  = 3'd0,
		REG_CENTRE = 3'd1,
		REG_ROT_A  = 3'd2,
		REG_ROT_B  = 3'd3,
		REG_ROT_C  = 3'd4,
		REG_ROT_D  = 3'd5,
		REG_ROT_E  = 3'd6,
		REG_SHIFT  = 3'd7
	} gpb_reg_t;

	// Focal length reset: 319.9988245766 rounded to f fraction bits, kept to 32 bits.
	function automatic logic [CFG_W-1:0] focal_reset(input int f);
		logic [63:0] fx;
		fx = (64'd319 << f) + (((64'd9988245766 << f) + 64'd5000000000) / 64'd10000000000);
		return {fx[31:0], fx[31:0]};
	endfunction

	function automatic logic [CFG_W-1:0] centre_reset(input int f);
		logic [63:0] u0;
		logic [63:0] v0;
		u0 = 64'd641 << (f - 1);
		v0 = 64'd481 << (f - 1);
		return {u0[31:0], v0[31:0]};
	endfunction

	// Quotient magnitude with sign to a saturated signed word; bit 32 is the saturation flag.
	function automatic logic [32:0] quo_sat(input logic [QUO_W-1:0] q, input logic neg,
		input logic ovf);
		logic big;
		logic [31:0] val;
		big = ovf || (neg ? (q > 32'h8000_0000) : q[31]);
		if (big)
			val = neg ? 32'h8000_0000 : 32'h7fff_ffff;
		else
			val = neg ? (32'd0 - q) : q;
		return {big, val};
	endfunction

	// Clamp a wide signed value to 32 bits; bit 32 is the saturation flag.
	function automatic logic [32:0] wide_sat(input logic signed [67:0] v);
		logic big;
		logic [31:0] val;
		big = !((&v[67:31]) || !(|v[67:31]));
		if (big)
			val = v[67] ? 32'h8000_0000 : 32'h7fff_ffff;
		else
			val = v[31:0];
		return {big, val};
	endfunction

	function automatic logic signed [67:0] sx68(input logic signed [63:0] v);
		return {{4{v[63]}}, v};
	endfunction

endpackage

/* src/gpb_div.sv */
// Pipelined unsigned long divider, one quotient bit per stage, 32-bit quotient.
// Carries a sign and a side payload; uses gpb_pkg.
module gpb_div #(
	parameter int NW = 56,
	parameter int DW = 32,
	parameter int PW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic neg,
	input  logic [PW-1:0] pay,
	output logic out_valid,
	output logic [gpb_pkg::QUO_W-1:0] quo,
	output logic ovf,
	output logic neg_out,
	output logic [PW-1:0] pay_out
);
	import gpb_pkg::*;

	localparam int HW = NW - QUO_W;
	localparam int CW = ((HW > DW) ? HW : DW) + 1;

	logic [CW-1:0] hi;
	logic [CW-1:0] dx;
	logic          big;

	logic [QUO_W:0]   v_s;
	logic [DW-1:0]    r_s [QUO_W+1];
	logic [QUO_W-1:0] n_s [QUO_W+1];
	logic [QUO_W-1:0] q_s [QUO_W+1];
	logic [DW-1:0]    d_s [QUO_W+1];
	logic             o_s [QUO_W+1];
	logic             g_s [QUO_W+1];
	logic [PW-1:0]    p_s [QUO_W+1];

	assign hi  = CW'(num[NW-1:QUO_W]);
	assign dx  = CW'(den);
	// A quotient of 2^32 or more shows already in the upper numerator bits.
	assign big = (hi >= dx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[QUO_W-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= big ? '0 : hi[DW-1:0];
			n_s[0] <= num[QUO_W-1:0];
			q_s[0] <= '0;
			d_s[0] <= den;
			o_s[0] <= big;
			g_s[0] <= neg;
			p_s[0] <= pay;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;
		assign t    = {r_s[k], n_s[k][QUO_W-1]};
		assign ge   = (t >= {1'b0, d_s[k]});
		assign diff = t - {1'b0, d_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
				n_s[k+1] <= {n_s[k][QUO_W-2:0], 1'b0};
				q_s[k+1] <= {q_s[k][QUO_W-2:0], ge};
				d_s[k+1] <= d_s[k];
				o_s[k+1] <= o_s[k];
				g_s[k+1] <= g_s[k];
				p_s[k+1] <= p_s[k];
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign quo       = q_s[QUO_W];
	assign ovf       = o_s[QUO_W];
	assign neg_out   = g_s[QUO_W];
	assign pay_out   = p_s[QUO_W];

	// The remainder must stay below the divisor at the output stage for every item that did not overflow.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QUO_W] && !o_s[QUO_W] |-> (r_s[QUO_W] < d_s[QUO_W]))
		else $error("gpb_div: remainder not below divisor");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s))
		else $error("gpb_div: valid bits moved during stall");

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s[0] |=> v_s[1])
		else $error("gpb_div: item lost between stages");

endmodule

/* src/ground_plane_backprojection.sv */
// Top level: foot point of a detection box projected onto the world ground plane.
// Depends on gpb_pkg and gpb_div (three pipelined dividers).
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tdata: box_left, box_top, box_width, box_height
//  m_*      out        m_tvalid/m_tready  tdata: world_x, world_y; tuser: no_hit
//  cfg_*    in         cfg_we             cfg_addr register index, cfg_data value
//
// One item per cycle enters unless the output stalls; the pipe holds two 33-stage dividers
// (foot point by focal length, then depth by ray denominator) plus ten arithmetic stages.
// Reset clears the valid bits and loads the default intrinsics with a zero pose.
// A held output stalls the whole pipeline in place; nothing is dropped or repeated.
module ground_plane_backprojection #(
	parameter int FRAC_BITS = gpb_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [4*gpb_pkg::BOX_W-1:0] s_tdata,   // box_left, box_top, box_width, box_height
	output logic m_tvalid,
	input  logic m_tready,
	output logic [2*gpb_pkg::OUT_W-1:0] m_tdata,   // world_x, world_y
	output logic m_tuser,                          // no_hit
	input  logic cfg_we,
	input  logic [gpb_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [gpb_pkg::CFG_W-1:0] cfg_data
);
	import gpb_pkg::*;

	localparam int XW  = 40;
	localparam int NW  = XW + FRAC_BITS;
	localparam int ZW  = 32 + FRAC_BITS;
	localparam int DNW = 66;
	localparam int ZPW = 2 * OUT_W + 3;

	logic [CFG_W-1:0] focal_q, centre_q, rot_a_q, rot_b_q, rot_c_q, rot_d_q, rot_e_q, shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q  <= focal_reset(FRAC_BITS);
			centre_q <= centre_reset(FRAC_BITS);
			rot_a_q  <= '0;
			rot_b_q  <= '0;
			rot_c_q  <= '0;
			rot_d_q  <= '0;
			rot_e_q  <= '0;
			shift_q  <= '0;
		end else if (cfg_we) begin
			case (gpb_reg_t'(cfg_addr))
				REG_FOCAL:  focal_q  <= cfg_data;
				REG_CENTRE: centre_q <= cfg_data;
				REG_ROT_A:  rot_a_q  <= cfg_data;
				REG_ROT_B:  rot_b_q  <= cfg_data;
				REG_ROT_C:  rot_c_q  <= cfg_data;
				REG_ROT_D:  rot_d_q  <= cfg_data;
				REG_ROT_E:  rot_e_q  <= cfg_data;
				REG_SHIFT:  shift_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	logic [31:0] fx, fy, u0, v0;
	logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22, tx, ty, tz;
	assign fx  = focal_q[63:32];
	assign fy  = focal_q[31:0];
	assign u0  = centre_q[63:32];
	assign v0  = centre_q[31:0];
	assign r00 = rot_a_q[63:32];
	assign r01 = rot_a_q[31:0];
	assign r02 = rot_b_q[63:32];
	assign r10 = rot_b_q[31:0];
	assign r11 = rot_c_q[63:32];
	assign r12 = rot_c_q[31:0];
	assign r20 = rot_d_q[63:32];
	assign r21 = rot_d_q[31:0];
	assign r22 = rot_e_q[63:32];
	assign tx  = rot_e_q[31:0];
	assign ty  = shift_q[63:32];
	assign tz  = shift_q[31:0];

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: foot point, offset from the principal point, numerator magnitudes.
	logic [17:0] sx;
	logic [16:0] sy;
	logic signed [XW-1:0] xd, yd;
	logic [XW-1:0] xm, ym;
	assign sx = {1'b0, s_tdata[15:0], 1'b0} + 18'(s_tdata[47:32]);
	assign sy = 17'(s_tdata[31:16]) + 17'(s_tdata[63:48]);
	assign xd = $signed(XW'(sx) << (FRAC_BITS - 5)) - $signed(XW'(u0));
	assign yd = $signed(XW'(sy) << (FRAC_BITS - 4)) - $signed(XW'(v0));
	assign xm = xd[XW-1] ? XW'(-xd) : XW'(xd);
	assign ym = yd[XW-1] ? XW'(-yd) : XW'(yd);

	logic          v_s1, xn_s1, yn_s1, fz_s1;
	logic [NW-1:0] xnum_s1, ynum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xnum_s1 <= NW'(xm) << FRAC_BITS;
			ynum_s1 <= NW'(ym) << FRAC_BITS;
			xn_s1   <= xd[XW-1];
			yn_s1   <= yd[XW-1];
			fz_s1   <= (fx == '0) || (fy == '0);
		end
	end

	logic        vx, vy, ox, oy, gx, gy, fzx, fzy;
	logic [31:0] qx, qy;

	gpb_div #(.NW(NW), .DW(32), .PW(1)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.num(xnum_s1), .den(fx), .neg(xn_s1), .pay(fz_s1),
		.out_valid(vx), .quo(qx), .ovf(ox), .neg_out(gx), .pay_out(fzx)
	);

	gpb_div #(.NW(NW), .DW(32), .PW(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.num(ynum_s1), .den(fy), .neg(yn_s1), .pay(fz_s1),
		.out_valid(vy), .quo(qy), .ovf(oy), .neg_out(gy), .pay_out(fzy)
	);

	// Stage 2: normalized ray nx, ny.
	logic [32:0] satx, saty;
	assign satx = quo_sat(qx, gx, ox);
	assign saty = quo_sat(qy, gy, oy);

	logic v_s2, flag_s2, fz_s2;
	logic signed [31:0] nx_s2, ny_s2;

	// Stage 3: ray denominator products.
	logic v_s3, flag_s3, fz_s3;
	logic signed [31:0] nx_s3, ny_s3;
	logic signed [63:0] mx_s3, my_s3;

	// Stage 4: ray denominator.
	logic v_s4, flag_s4, fz_s4;
	logic signed [31:0] nx_s4, ny_s4;
	logic signed [DNW-1:0] den_s4;

	// Stage 5: divisor magnitude and quotient sign for the depth.
	logic v_s5, flag_s5, fz_s5, dz_s5, zn_s5;
	logic signed [31:0] nx_s5, ny_s5;
	logic [DNW-1:0] dmag_s5;
	logic [ZW-1:0]  znum_s5;

	logic signed [63:0] flmx, flmy;
	logic [31:0] tzm;
	assign flmx = mx_s3 >>> FRAC_BITS;
	assign flmy = my_s3 >>> FRAC_BITS;
	assign tzm  = tz[31] ? (32'd0 - tz) : tz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s2 <= vx && vy;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2   <= satx[31:0];
			ny_s2   <= saty[31:0];
			flag_s2 <= satx[32] || saty[32];
			fz_s2   <= fzx || fzy;

			mx_s3   <= r20 * nx_s2;
			my_s3   <= r21 * ny_s2;
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;
			flag_s3 <= flag_s2;
			fz_s3   <= fz_s2;

			den_s4  <= DNW'(flmx) + DNW'(flmy) + DNW'(r22);
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			flag_s4 <= flag_s3;
			fz_s4   <= fz_s3;

			dmag_s5 <= den_s4[DNW-1] ? DNW'(-den_s4) : DNW'(den_s4);
			dz_s5   <= (den_s4 == '0);
			// The depth numerator is -tz, so it is negative when tz is positive.
			zn_s5   <= (!tz[31] && (tz != '0)) ^ den_s4[DNW-1];
			znum_s5 <= ZW'(tzm) << FRAC_BITS;
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
			flag_s5 <= flag_s4;
			fz_s5   <= fz_s4;
		end
	end

	logic           vz, oz, gz;
	logic [31:0]    qz;
	logic [ZPW-1:0] zpay;

	gpb_div #(.NW(ZW), .DW(DNW), .PW(ZPW)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(znum_s5), .den(dmag_s5), .neg(zn_s5),
		.pay({nx_s5, ny_s5, flag_s5, fz_s5, dz_s5}),
		.out_valid(vz), .quo(qz), .ovf(oz), .neg_out(gz), .pay_out(zpay)
	);

	logic [32:0] satz;
	assign satz = quo_sat(qz, gz, oz);

	// Stage 6: depth zc.  Stage 7: camera-frame products.  Stage 8: px, py.
	logic v_s6, flag_s6, fz_s6, dz_s6;
	logic signed [31:0] nx_s6, ny_s6, zc_s6;
	logic v_s7, flag_s7, fz_s7, dz_s7;
	logic signed [31:0] zc_s7;
	logic signed [63:0] mpx_s7, mpy_s7;
	logic v_s8, flag_s8, fz_s8, dz_s8;
	logic signed [31:0] zc_s8, px_s8, py_s8;
	// Stage 9: rotation products.
	logic v_s9, flag_s9, fz_s9, dz_s9;
	logic signed [63:0] m00_s9, m01_s9, m02_s9, m10_s9, m11_s9, m12_s9;

	logic [32:0] satpx, satpy, satwx, satwy;
	logic signed [67:0] sumx, sumy;
	assign satpx = wide_sat(sx68(mpx_s7 >>> FRAC_BITS));
	assign satpy = wide_sat(sx68(mpy_s7 >>> FRAC_BITS));
	assign sumx  = sx68(m00_s9 >>> FRAC_BITS) + sx68(m01_s9 >>> FRAC_BITS)
		+ sx68(m02_s9 >>> FRAC_BITS) + 68'(tx);
	assign sumy  = sx68(m10_s9 >>> FRAC_BITS) + sx68(m11_s9 >>> FRAC_BITS)
		+ sx68(m12_s9 >>> FRAC_BITS) + 68'(ty);
	assign satwx = wide_sat(sumx);
	assign satwy = wide_sat(sumy);

	logic kill;
	assign kill = fz_s9 || dz_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s6     <= vz;
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			v_s9     <= v_s8;
			m_tvalid <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			{nx_s6, ny_s6} <= zpay[ZPW-1:3];
			flag_s6 <= zpay[2] || satz[32];
			fz_s6   <= zpay[1];
			dz_s6   <= zpay[0];
			zc_s6   <= satz[31:0];

			mpx_s7  <= nx_s6 * zc_s6;
			mpy_s7  <= ny_s6 * zc_s6;
			zc_s7   <= zc_s6;
			flag_s7 <= flag_s6;
			fz_s7   <= fz_s6;
			dz_s7   <= dz_s6;

			px_s8   <= satpx[31:0];
			py_s8   <= satpy[31:0];
			zc_s8   <= zc_s7;
			flag_s8 <= flag_s7 || satpx[32] || satpy[32];
			fz_s8   <= fz_s7;
			dz_s8   <= dz_s7;

			m00_s9  <= r00 * px_s8;
			m01_s9  <= r01 * py_s8;
			m02_s9  <= r02 * zc_s8;
			m10_s9  <= r10 * px_s8;
			m11_s9  <= r11 * py_s8;
			m12_s9  <= r12 * zc_s8;
			flag_s9 <= flag_s8;
			fz_s9   <= fz_s8;
			dz_s9   <= dz_s8;

			// A zero focal length or a ray parallel to the ground gives a zero point.
			m_tdata <= kill ? '0 : {satwy[31:0], satwx[31:0]};
			m_tuser <= kill || flag_s9 || satwx[32] || satwy[32];
		end
	end

	a_kill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s9 && kill |=> m_tvalid && m_tuser && (m_tdata == '0))
		else $error("gpb: degenerate ray did not give a flagged zero point");

	a_xy_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		vx == vy)
		else $error("gpb: x and y dividers out of step");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s2, v_s5, v_s6, v_s9}))
		else $error("gpb: pipeline moved during stall");

endmodule

/* test/tb.sv */
// Testbench for ground_plane_backprojection: directed boxes from a table, then random boxes,
// each checked against its row or a fixed-point predictor. Depends on gpb_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gpb_pkg::*;

	localparam int F = 16;
	localparam int LAT = 76;
	localparam int WD_LIMIT = 20000;
	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] wy;
		logic [31:0] wx;
		logic        miss;
	} ground_pt_t;

	typedef struct {
		logic [15:0] lf, tp, wd, ht;
		logic        fixed;
		ground_pt_t  pt;
	} box_row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [63:0] s_tdata, m_tdata;
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [63:0] cfg_data;

	logic [63:0] cam_regs [NUM_REGS];
	ground_pt_t expected_pts[$];
	int errors = 0;
	int idle_cnt = 0;
	bit no_idle = 0;
	bit hold_out = 0;

	ground_plane_backprojection #(.FRAC_BITS(F)) i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint fl(longint v);
		return v >>> F;
	endfunction

	function automatic longint sat(longint v, ref bit f);
		if (v > MAX32) begin f = 1; return MAX32; end
		if (v < MIN32) begin f = 1; return MIN32; end
		return v;
	endfunction

	function automatic longint hs(logic [63:0] r);
		return longint'($signed(r[63:32]));
	endfunction

	function automatic longint ls(logic [63:0] r);
		return longint'($signed(r[31:0]));
	endfunction

	function automatic ground_pt_t project_box(logic [15:0] lf, tp, wd, ht);
		ground_pt_t p;
		longint fx, fy, u0, v0, nx, ny, den, zc, px, py, wx, wy, xx, yy;
		bit f;
		f = 0; wx = 0; wy = 0;
		fx = longint'(cam_regs[0][63:32]); fy = longint'(cam_regs[0][31:0]);
		u0 = longint'(cam_regs[1][63:32]); v0 = longint'(cam_regs[1][31:0]);
		if (fx != 0 && fy != 0) begin
			xx = ((2 * longint'(lf) + longint'(wd)) <<< F) / 32;
			yy = ((longint'(tp) + longint'(ht)) <<< F) / 16;
			nx = sat(((xx - u0) <<< F) / fx, f);
			ny = sat(((yy - v0) <<< F) / fy, f);
			den = fl(hs(cam_regs[5]) * nx) + fl(ls(cam_regs[5]) * ny) + hs(cam_regs[6]);
			if (den != 0) begin
				zc = sat(((-ls(cam_regs[7])) <<< F) / den, f);
				px = sat(fl(nx * zc), f);
				py = sat(fl(ny * zc), f);
				wx = sat(fl(hs(cam_regs[2]) * px) + fl(ls(cam_regs[2]) * py)
					+ fl(hs(cam_regs[3]) * zc) + ls(cam_regs[6]), f);
				wy = sat(fl(ls(cam_regs[3]) * px) + fl(hs(cam_regs[4]) * py)
					+ fl(ls(cam_regs[4]) * zc) + hs(cam_regs[7]), f);
			end else
				f = 1;
		end else
			f = 1;
		p.wx = wx[31:0]; p.wy = wy[31:0]; p.miss = f;
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic write_reg(gpb_reg_t idx, logic [63:0] val);
		cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		cam_regs[idx] = val;
		@(negedge clk);
	endtask

	// Waits until every expected word has come back and the pipeline has drained.
	task automatic drain();
		s_tvalid <= 0;
		while (expected_pts.size() != 0) @(negedge clk);
		repeat (LAT + 8) @(negedge clk);
	endtask

	task automatic send_item(logic [15:0] lf, tp, wd, ht, ground_pt_t want);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {ht, wd, tp, lf};
		expected_pts.push_back(want);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_box(logic [15:0] lf, tp, wd, ht);
		send_item(lf, tp, wd, ht, project_box(lf, tp, wd, ht));
	endtask

	// Rows with a typed expectation are checked against it, the others against the predictor.
	task automatic send_row(box_row_t r);
		send_item(r.lf, r.tp, r.wd, r.ht,
			r.fixed ? r.pt : project_box(r.lf, r.tp, r.wd, r.ht));
	endtask

	// Random pose: mostly plausible small values, sometimes full-range words.
	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h0001_0000;
			2: return 32'hffff_0000;
			default: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
		endcase
	endfunction

	task automatic random_pose(int mode);
		write_reg(REG_FOCAL, mode == 0 ? {$urandom(), $urandom()}
			: {32'h0100_0000 + $urandom_range(0, 32'hff_ffff),
			32'h0080_0000 + $urandom_range(0, 32'hff_ffff)});
		write_reg(REG_CENTRE, mode == 0 ? {$urandom(), $urandom()}
			: {32'h0140_0000 + $urandom_range(0, 32'hfffff),
			32'h00f0_0000 + $urandom_range(0, 32'hfffff)});
		write_reg(REG_ROT_A, {rand_q(), rand_q()});
		write_reg(REG_ROT_B, {rand_q(), rand_q()});
		write_reg(REG_ROT_C, {rand_q(), rand_q()});
		write_reg(REG_ROT_D, {rand_q(), rand_q()});
		write_reg(REG_ROT_E, {rand_q(), rand_q()});
		write_reg(REG_SHIFT, {rand_q(), rand_q()});
	endtask

	always @(posedge clk) begin
		ground_pt_t w;
		if (m_tvalid && m_tready) begin
			if (expected_pts.size() == 0) begin
				report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
			end else begin
				w = expected_pts.pop_front();
				if (m_tdata[31:0] !== w.wx) report_mismatch("world_x", m_tdata[31:0], w.wx);
				if (m_tdata[63:32] !== w.wy) report_mismatch("world_y", m_tdata[63:32], w.wy);
				if (m_tuser !== w.miss)
					report_mismatch("no_hit", 32'(m_tuser), 32'(w.miss));
			end
		end
	end

	// Receiver backpressure; a long hold-off fills the pipeline at least once.
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out) begin
				m_tready <= 0;
				repeat (300) @(negedge clk);
				hold_out = 0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			m_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WD_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		box_row_t rows[$];
		ground_pt_t z;
		int mode;
		arst_n = 0; s_tvalid = 0; s_tdata = 0;
		cfg_we = 0; cfg_addr = 0; cfg_data = 0;
		cam_regs[0] = focal_reset(F);
		cam_regs[1] = centre_reset(F);
		for (int i = 2; i < NUM_REGS; i++) cam_regs[i] = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// With the reset pose the ray denominator is zero, so every box misses.
		z = '{wx: 0, wy: 0, miss: 1};
		rows.push_back('{16'h0, 16'h0, 16'h0, 16'h0, 1, z});
		rows.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, z});
		rows.push_back('{16'h1400, 16'h0f00, 16'h0200, 16'h0100, 1, z});
		foreach (rows[i]) send_row(rows[i]);
		drain();

		// Camera one metre up, looking straight down; then extremes and zero focal length.
		write_reg(REG_ROT_A, {32'h0001_0000, 32'h0});
		write_reg(REG_ROT_B, {32'h0, 32'h0});
		write_reg(REG_ROT_C, {32'hffff_0000, 32'h0});
		write_reg(REG_ROT_D, {32'h0, 32'h0});
		write_reg(REG_ROT_E, {32'hffff_0000, 32'h0});
		write_reg(REG_SHIFT, {32'h0, 32'h0001_0000});
		rows.delete();
		rows.push_back('{16'h0, 16'h0, 16'h0, 16'h0, 0, z});
		rows.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, z});
		rows.push_back('{16'h1400, 16'h0f00, 16'h0020, 16'h0010, 0, z});
		rows.push_back('{16'h8000, 16'h0001, 16'h7fff, 16'h0, 0, z});
		foreach (rows[i]) send_row(rows[i]);
		drain();
		write_reg(REG_SHIFT, {32'h8000_0000, 32'h7fff_ffff});
		write_reg(REG_FOCAL, {32'h0000_0001, 32'h0000_0001});
		for (int i = 0; i < 4; i++) send_box($urandom(), $urandom(), $urandom(), $urandom());
		drain();
		write_reg(REG_FOCAL, 64'h0);
		write_reg(REG_CENTRE, {32'hffff_ffff, 32'hffff_ffff});
		rows.delete();
		rows.push_back('{16'h1234, 16'h0100, 16'h0100, 16'h0100, 1, z});
		rows.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, z});
		foreach (rows[i]) send_row(rows[i]);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			mode = (ph % 3 == 0) ? 0 : 1;
			random_pose(mode);
			if (ph == 5) hold_out = 1;
			if (ph == 10) no_idle = 1;
			for (int i = 0; i < 120; i++)
				send_box($urandom(), $urandom(), $urandom(), $urandom());
			drain();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
